>>> sv/bm3_pkg.sv
// shared types, constants and widths of the 3x3 edge-aware box mean filter
package bm3_pkg;

    localparam int MAX_SIZE_DEF   = 32;
    localparam int FIFO_DEPTH_DEF = 8;
    localparam int SIZE_RESET     = 8;

    localparam int CFG_W   = 6;
    localparam int PIX_W   = 8;
    localparam int POS_W   = 5;
    localparam int CSUM_W  = 10;
    localparam int SUM_W   = 12;
    localparam int RECIP_W = 15;
    localparam int FRAC_W  = 16;
    localparam int TDATA_W = 24;

    // reciprocals scaled by 2**FRAC_W, exact for sums below 2**SUM_W
    localparam logic [RECIP_W-1:0] RECIP4 = 15'd16384;
    localparam logic [RECIP_W-1:0] RECIP6 = 15'd10923;
    localparam logic [RECIP_W-1:0] RECIP9 = 15'd7282;

    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } div_sel_t;

    typedef struct packed {
        logic [PIX_W-1:0] l1;
        logic [PIX_W-1:0] l2;
    } cell_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        div_sel_t         dsel;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
        logic             done;
    } pend_t;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
        logic             done;
    } result_t;

endpackage

>>> sv/bm3_cell.sv
// one cell of the two chained line stores, shifting toward column zero
module bm3_cell (
    input  logic                      aclk,
    input  logic                      shift_en,
    input  logic                      entry,
    input  logic [bm3_pkg::PIX_W-1:0] pix,
    input  logic [bm3_pkg::PIX_W-1:0] tap,
    input  bm3_pkg::cell_t            right,
    output bm3_pkg::cell_t            q
);
    import bm3_pkg::*;

    cell_t q_reg;
    cell_t q_next;

    always_comb begin
        q_next = q_reg;
        if (shift_en) begin
            if (entry) begin
                q_next.l1 = pix;
                q_next.l2 = tap;
            end else begin
                q_next = right;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

>>> sv/bm3_div.sv
// division of a neighborhood sum by its pixel count through a scaled reciprocal
module bm3_div (
    input  bm3_pkg::pend_t   pend,
    output bm3_pkg::result_t res
);
    import bm3_pkg::*;

    logic [RECIP_W-1:0]       recip;
    logic [SUM_W+RECIP_W-1:0] prod;

    always_comb begin
        unique case (pend.dsel)
            DIV4:    recip = RECIP4;
            DIV6:    recip = RECIP6;
            DIV9:    recip = RECIP9;
            default: recip = RECIP4;
        endcase
    end

    assign prod = {{RECIP_W{1'b0}}, pend.sum} * {{SUM_W{1'b0}}, recip};

    assign res.mean = prod[FRAC_W +: PIX_W];
    assign res.row  = pend.row;
    assign res.col  = pend.col;
    assign res.last = pend.last;
    assign res.done = pend.done;

endmodule

>>> sv/bm3_fifo.sv
// result queue taking up to two results per cycle and giving one
module bm3_fifo #(
    parameter int DEPTH = bm3_pkg::FIFO_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bm3_pkg::result_t             wr_a,
    input  logic                         wr_a_en,
    input  bm3_pkg::result_t             wr_b,
    input  logic                         wr_b_en,
    input  logic                         rd_en,
    output bm3_pkg::result_t             rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    import bm3_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [AW-1:0]   wr_ptr_b;

    assign wr_ptr_b    = wr_ptr_reg + AW'(wr_a_en);
    assign wr_ptr_next = wr_ptr_b + AW'(wr_b_en);
    assign rd_ptr_next = rd_ptr_reg + AW'(rd_en);
    assign count_next  = count_reg + CW'(wr_a_en) + CW'(wr_b_en) - CW'(rd_en);

    always_ff @(posedge aclk) begin
        if (wr_a_en) begin
            mem_reg[wr_ptr_reg] <= wr_a;
        end
        if (wr_b_en) begin
            mem_reg[wr_ptr_b] <= wr_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

>>> sv/box_mean_3x3_edge_aware.sv
// top level of the streaming 3x3 edge-aware box mean filter
//
// Takes one pixel per cycle in raster order and returns the truncated mean of
// each pixel's in-image 3x3 neighborhood, one result per cycle, in raster
// order. The two earlier rows live in a chain of MAX_SIZE cells that shifts
// once per pixel, with the entry point set by the image size, so no clearing
// pass is needed after reset. A result is registered in the s1 stage once the
// pixel that completes it is accepted and is written from there into the
// output queue. Inside a frame the input runs at one pixel per cycle as long
// as the output is drained at one result per cycle; the two results of a row
// end fit the FIFO_DEPTH-entry result queue. After the final pixel of a frame
// the block flushes the last row, taking no pixel meanwhile. Writing image_size
// restarts the frame; values below 2 are taken as 2 and values above MAX_SIZE as
// MAX_SIZE. FIFO_DEPTH must be a power of two of at least 4; the block does not check it.
module box_mean_3x3_edge_aware #(
    parameter int MAX_SIZE   = bm3_pkg::MAX_SIZE_DEF,
    parameter int FIFO_DEPTH = bm3_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [bm3_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [bm3_pkg::PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel_value
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [bm3_pkg::TDATA_W-1:0] m_axis_tdata,   // [7:0] mean_value, [12:8] out_row,
                                                        // [17:13] out_col
    output logic                        m_axis_tlast,   // last_of_run
    output logic [0:0]                  m_axis_tuser    // [0] frame_done
);
    import bm3_pkg::*;

    localparam int SW    = $clog2(MAX_SIZE + 1);
    localparam int CW    = $clog2(MAX_SIZE);
    localparam int CNTW  = $clog2(FIFO_DEPTH + 1);
    localparam int CRW   = CNTW + 1;
    localparam int PAD_W = TDATA_W - PIX_W - 2 * POS_W;
    localparam int RST_SIZE = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;
    localparam logic [CFG_W-1:0] MAX_CFG = CFG_W'(MAX_SIZE);
    localparam logic [CFG_W-1:0] MIN_CFG = CFG_W'(2);

    logic [SW-1:0]     n_reg;
    logic [SW-1:0]     n_next;
    logic [SW-1:0]     row_reg;
    logic [SW-1:0]     row_next;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [CW-1:0]     n_m1;
    logic [CFG_W-1:0]  cfg_size;

    logic              flushing;
    logic              final_in;
    logic              col_last;
    logic              top_en;
    logic              bot_en;
    logic              colge1;
    logic              colge2;
    logic              credit_ok;
    logic              step;
    logic              emit;
    logic [CRW-1:0]    occ;

    cell_t             cell_q [MAX_SIZE];

    logic [CSUM_W-1:0] cs;
    logic [CSUM_W-1:0] cs1_reg;
    logic [CSUM_W-1:0] cs2_reg;
    logic [SUM_W-1:0]  sum_a;
    logic [SUM_W-1:0]  sum_b;
    div_sel_t          dsel_a;
    div_sel_t          dsel_b;
    pend_t             pend_a;
    pend_t             pend_b;
    pend_t             s1_a_reg;
    pend_t             s1_b_reg;
    logic              s1_a_vld_reg;
    logic              s1_a_vld_next;
    logic              s1_b_vld_reg;
    logic              s1_b_vld_next;
    logic [1:0]        s1_cnt;

    result_t           res_a;
    result_t           res_b;
    result_t           head;
    logic [CNTW-1:0]   fifo_cnt;
    logic              pop;

    // position decode
    assign n_m1     = CW'(n_reg - 1'b1);
    assign flushing = (row_reg == n_reg);
    assign col_last = (col_reg == n_m1);
    assign final_in = (row_reg == SW'(n_reg - 1'b1)) && col_last;
    assign top_en   = (row_reg >= SW'(2));
    assign bot_en   = !flushing;
    assign colge1   = (col_reg != '0);
    assign colge2   = (col_reg > CW'(1));

    assign s1_cnt    = {1'b0, s1_a_vld_reg} + {1'b0, s1_b_vld_reg};
    assign occ       = CRW'(fifo_cnt) + CRW'(s1_cnt);
    assign credit_ok = (occ <= CRW'(FIFO_DEPTH - 2));

    assign s_axis_tready = credit_ok && !flushing;
    assign step = (s_axis_tvalid && s_axis_tready) || (flushing && credit_ok);
    assign emit = step && (row_reg != '0);

    // line store chain
    for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
        cell_t right;
        if (k == MAX_SIZE - 1) begin : g_end
            assign right = '0;
        end else begin : g_mid
            assign right = cell_q[k+1];
        end
        bm3_cell u_cell (
            .aclk     (aclk),
            .shift_en (step),
            .entry    (CW'(k) == n_m1),
            .pix      (s_axis_tdata),
            .tap      (cell_q[0].l1),
            .right    (right),
            .q        (cell_q[k])
        );
    end

    // column sums and horizontal window
    assign cs = CSUM_W'(top_en ? cell_q[0].l2 : {PIX_W{1'b0}})
              + CSUM_W'(cell_q[0].l1)
              + CSUM_W'(bot_en ? s_axis_tdata : {PIX_W{1'b0}});

    always_ff @(posedge aclk) begin
        if (step) begin
            cs1_reg <= cs;
            cs2_reg <= cs1_reg;
        end
    end

    assign sum_a = SUM_W'(cs) + SUM_W'(cs1_reg)
                 + SUM_W'(colge2 ? cs2_reg : {CSUM_W{1'b0}});
    assign sum_b = SUM_W'(cs) + SUM_W'(cs1_reg);

    always_comb begin
        if (top_en && bot_en) begin
            dsel_a = colge2 ? DIV9 : DIV6;
            dsel_b = DIV6;
        end else begin
            dsel_a = colge2 ? DIV6 : DIV4;
            dsel_b = DIV4;
        end
    end

    always_comb begin
        pend_a.sum  = sum_a;
        pend_a.dsel = dsel_a;
        pend_a.row  = POS_W'(row_reg - 1'b1);
        pend_a.col  = POS_W'(col_reg - 1'b1);
        pend_a.last = !col_last && !flushing;
        pend_a.done = final_in || flushing;
        pend_b.sum  = sum_b;
        pend_b.dsel = dsel_b;
        pend_b.row  = POS_W'(row_reg - 1'b1);
        pend_b.col  = POS_W'(col_reg);
        pend_b.last = !final_in;
        pend_b.done = final_in || flushing;
    end

    assign s1_a_vld_next = emit && colge1;
    assign s1_b_vld_next = emit && col_last;

    always_ff @(posedge aclk) begin
        s1_a_reg <= pend_a;
        s1_b_reg <= pend_b;
    end

    // sequencer: row n_reg is the flush of the last image row
    always_comb begin
        cfg_size = cfg_wr_data;
        if (cfg_wr_data < MIN_CFG) begin
            cfg_size = MIN_CFG;
        end else if (cfg_wr_data > MAX_CFG) begin
            cfg_size = MAX_CFG;
        end
    end

    always_comb begin
        n_next   = n_reg;
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_wr_en) begin
            n_next   = SW'(cfg_size);
            row_next = '0;
            col_next = '0;
        end else if (step) begin
            if (col_last) begin
                col_next = '0;
                row_next = flushing ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg        <= SW'(RST_SIZE);
            row_reg      <= '0;
            col_reg      <= '0;
            s1_a_vld_reg <= 1'b0;
            s1_b_vld_reg <= 1'b0;
        end else begin
            n_reg        <= n_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_a_vld_reg <= s1_a_vld_next;
            s1_b_vld_reg <= s1_b_vld_next;
        end
    end

    // divide and queue
    bm3_div u_div_a (
        .pend (s1_a_reg),
        .res  (res_a)
    );

    bm3_div u_div_b (
        .pend (s1_b_reg),
        .res  (res_b)
    );

    bm3_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_a    (res_a),
        .wr_a_en (s1_a_vld_reg),
        .wr_b    (res_b),
        .wr_b_en (s1_b_vld_reg),
        .rd_en   (pop),
        .rd_data (head),
        .count   (fifo_cnt)
    );

    assign m_axis_tvalid   = (fifo_cnt != '0);
    assign pop             = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata    = {{PAD_W{1'b0}}, head.col, head.row, head.mean};
    assign m_axis_tlast    = head.last;
    assign m_axis_tuser[0] = head.done;

    // queue plus results in flight never exceed the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(fifo_cnt) + 32'(s1_cnt)) <= FIFO_DEPTH)
        else $error("result queue overflow");

    // a row-end result always comes with a regular one of the same transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_b_vld_reg |-> s1_a_vld_reg)
        else $error("row-end result without its partner");

    // the end of the flush returns to the frame start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && flushing && col_last) |=> (row_reg == '0 && col_reg == '0))
        else $error("flush did not return to frame start");

    // position stays inside the image or the flush row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg <= n_reg) && (SW'(col_reg) < n_reg))
        else $error("position out of range");

endmodule
